// ===== hdl/xalu_pkg.sv =====
// Package for the x86-style integer ALU: operation and size codes, flag record.
// No dependencies. Used by the channel interfaces and the top level.
package xalu_pkg;

	localparam int DATA_W = 32;
	localparam int KIND_W = 5;
	localparam int SIZE_W = 2;

	typedef enum logic [KIND_W-1:0] {
		K_ADD  = 5'd0,
		K_SUB  = 5'd1,
		K_ADC  = 5'd2,
		K_SBB  = 5'd3,
		K_INC  = 5'd4,
		K_DEC  = 5'd5,
		K_AND  = 5'd6,
		K_OR   = 5'd7,
		K_XOR  = 5'd8,
		K_CMP  = 5'd9,
		K_TEST = 5'd10,
		K_SHR  = 5'd11,
		K_SAR  = 5'd12,
		K_SHL  = 5'd13,
		K_ROL  = 5'd14,
		K_ROR  = 5'd15,
		K_NEG  = 5'd16
	} kind_t;

	typedef enum logic [SIZE_W-1:0] {
		SZ_8  = 2'd0,
		SZ_16 = 2'd1,
		SZ_32 = 2'd2
	} size_t;

	typedef struct packed {
		logic o;
		logic s;
		logic z;
		logic c;
	} flags_t;

endpackage

// ===== hdl/xalu_req_if.sv =====
// Request channel of the ALU: valid/ready handshake carrying one operation.
// Depends on xalu_pkg for field widths.
interface xalu_req_if;
	logic                          valid;
	logic                          ready;
	logic [xalu_pkg::KIND_W-1:0]   kind;
	logic [xalu_pkg::SIZE_W-1:0]   size_code;
	logic [xalu_pkg::DATA_W-1:0]   operand_a;
	logic [xalu_pkg::DATA_W-1:0]   operand_b;

	modport source (output valid, kind, size_code, operand_a, operand_b, input ready);
	modport sink   (input valid, kind, size_code, operand_a, operand_b, output ready);
endinterface

// ===== hdl/xalu_rsp_if.sv =====
// Response channel of the ALU: valid/ready handshake carrying result and flags.
// Depends on xalu_pkg for field widths.
interface xalu_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [xalu_pkg::DATA_W-1:0]   result_value;
	logic                          carry_out;
	logic                          zero_out;
	logic                          sign_out;
	logic                          overflow_out;

	modport source (output valid, result_value, carry_out, zero_out, sign_out, overflow_out,
		input ready);
	modport sink   (input valid, result_value, carry_out, zero_out, sign_out, overflow_out,
		output ready);
endinterface

// ===== hdl/x86_integer_alu_flags.sv =====
// x86-style integer ALU with carry, zero, sign and overflow flags.
// Depends on xalu_pkg, xalu_req_if and xalu_rsp_if.
//
// Usage:
//   req carries one operation per transaction (kind, size_code, operand_a, operand_b);
//   rsp returns the new destination value and the four flags after it.
//   Transactions complete in order, one response per request.
// Path: input register -> result register; rsp.valid is high while it holds one.
// Throughput: one transaction per cycle while rsp.ready is high. The stored
//   flags are read and rewritten by the single compute stage between the
//   input and result registers, so dependent operations (adc, sbb, inc, dec,
//   shifts) issue back to back.
// Reset: arst_n clears both stage valids and the stored flags to zero.
// Stall: while rsp.ready is low the result register holds its transaction; the
//   input register still takes one more request, after which req.ready drops
//   until the result is taken.
module x86_integer_alu_flags (
	input  logic clk,
	input  logic arst_n,
	xalu_req_if.sink   req,
	xalu_rsp_if.source rsp
);
	import xalu_pkg::*;

	logic                valid_s1;
	logic [KIND_W-1:0]   kind_s1;
	logic [SIZE_W-1:0]   size_s1;
	logic [DATA_W-1:0]   a_s1;
	logic [DATA_W-1:0]   b_s1;

	logic                rsp_valid_q;
	logic [DATA_W-1:0]   result_q;
	flags_t              flags_q;

	logic                load_out;
	logic                advance;

	logic [DATA_W-1:0]   mask;
	logic [DATA_W-1:0]   a;
	logic [DATA_W-1:0]   b;
	logic [4:0]          cnt;
	logic                sa;
	logic                sb;

	logic [DATA_W-1:0]   addend;
	logic                add_cin;
	logic [DATA_W:0]     add_full;
	logic [DATA_W-1:0]   add_res;
	logic [DATA_W-1:0]   subtr;
	logic                sub_cin;
	logic [DATA_W:0]     sub_total;
	logic [DATA_W:0]     sub_full;
	logic [DATA_W-1:0]   sub_res;
	logic [DATA_W-1:0]   logic_v;
	logic [DATA_W-1:0]   shr_v;
	logic                shr_c;
	logic [DATA_W-1:0]   sar_src;
	logic [DATA_W-1:0]   sar_v;
	logic                sar_c;
	logic [2*DATA_W-1:0] shl_wide;
	logic [DATA_W-1:0]   shl_v;
	logic                shl_c;

	logic [DATA_W-1:0]   res;
	flags_t              nf;

	function automatic logic msb_of(input logic [DATA_W-1:0] v, input logic [SIZE_W-1:0] sz);
		logic r;
		unique case (sz)
			SZ_8:    r = v[7];
			SZ_16:   r = v[15];
			default: r = v[31];
		endcase
		return r;
	endfunction

	function automatic logic carry_of(input logic [2*DATA_W-1:0] v,
		input logic [SIZE_W-1:0] sz);
		logic r;
		unique case (sz)
			SZ_8:    r = v[8];
			SZ_16:   r = v[16];
			default: r = v[32];
		endcase
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] rotate(input logic [DATA_W-1:0] v,
		input logic [SIZE_W-1:0] sz, input logic [4:0] n, input logic left);
		logic [15:0]         d8;
		logic [31:0]         d16;
		logic [63:0]         d32;
		logic [DATA_W-1:0]   r;
		d8  = {v[7:0], v[7:0]};
		d16 = {v[15:0], v[15:0]};
		d32 = {v, v};
		if (left) begin
			d8  = d8 << n[2:0];
			d16 = d16 << n[3:0];
			d32 = d32 << n;
			unique case (sz)
				SZ_8:    r = {24'd0, d8[15:8]};
				SZ_16:   r = {16'd0, d16[31:16]};
				default: r = d32[63:32];
			endcase
		end else begin
			d8  = d8 >> n[2:0];
			d16 = d16 >> n[3:0];
			d32 = d32 >> n;
			unique case (sz)
				SZ_8:    r = {24'd0, d8[7:0]};
				SZ_16:   r = {16'd0, d16[15:0]};
				default: r = d32[31:0];
			endcase
		end
		return r;
	endfunction

	// handshake
	assign load_out  = !rsp_valid_q || rsp.ready;
	assign advance   = valid_s1 && load_out;
	assign req.ready = !valid_s1 || load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_s1 <= req.kind;
			size_s1 <= req.size_code;
			a_s1    <= req.operand_a;
			b_s1    <= req.operand_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			flags_q     <= '0;
		end else begin
			if (load_out) begin
				rsp_valid_q <= valid_s1;
			end
			if (advance) begin
				flags_q <= nf;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= res;
		end
	end

	// operand prep
	always_comb begin
		unique case (size_s1)
			SZ_8:    mask = 32'h0000_00FF;
			SZ_16:   mask = 32'h0000_FFFF;
			default: mask = 32'hFFFF_FFFF;
		endcase
	end

	assign a   = a_s1 & mask;
	assign b   = b_s1 & mask;
	assign cnt = b_s1[4:0];
	assign sa  = msb_of(a, size_s1);
	assign sb  = msb_of(b, size_s1);

	// add / adc / inc
	assign addend   = (kind_s1 == K_INC) ? 32'd1 : b;
	assign add_cin  = (kind_s1 == K_ADC) ? flags_q.c : 1'b0;
	assign add_full = {1'b0, a} + {1'b0, addend} + {{DATA_W{1'b0}}, add_cin};
	assign add_res  = add_full[DATA_W-1:0] & mask;

	// sub / sbb / dec / cmp; subtrahend plus borrow is not wrapped
	assign subtr     = (kind_s1 == K_DEC) ? 32'd1 : b;
	assign sub_cin   = (kind_s1 == K_SBB) ? flags_q.c : 1'b0;
	assign sub_total = {1'b0, subtr} + {{DATA_W{1'b0}}, sub_cin};
	assign sub_full  = {1'b0, a} - sub_total;
	assign sub_res   = sub_full[DATA_W-1:0] & mask;

	always_comb begin
		unique case (kind_s1)
			K_OR:    logic_v = a | b;
			K_XOR:   logic_v = a ^ b;
			default: logic_v = a & b;
		endcase
	end

	// shifts
	assign shr_v    = a >> cnt;
	assign shr_c    = a[cnt - 5'd1];
	assign sar_src  = a | (sa ? ~mask : '0);
	assign sar_v    = DATA_W'($signed(sar_src) >>> cnt) & mask;
	assign sar_c    = sar_src[cnt - 5'd1];
	assign shl_wide = {{DATA_W{1'b0}}, a} << cnt;
	assign shl_v    = shl_wide[DATA_W-1:0] & mask;
	assign shl_c    = carry_of(shl_wide, size_s1);

	always_comb begin
		nf  = flags_q;
		res = a;
		unique case (kind_s1)
			K_ADD, K_ADC, K_INC: begin
				res = add_res;
				if (kind_s1 != K_INC) begin
					nf.c = carry_of({{(DATA_W-1){1'b0}}, add_full}, size_s1);
				end
				nf.o = (sa == msb_of(addend, size_s1)) && (msb_of(add_res, size_s1) != sa);
				nf.z = (add_res == '0);
				nf.s = msb_of(add_res, size_s1);
			end
			K_SUB, K_SBB, K_DEC, K_CMP: begin
				res = (kind_s1 == K_CMP) ? a : sub_res;
				if (kind_s1 != K_DEC) begin
					nf.c = sub_full[DATA_W];
				end
				nf.o = (sa != msb_of(subtr, size_s1)) && (msb_of(sub_res, size_s1) != sa);
				nf.z = (sub_res == '0);
				nf.s = msb_of(sub_res, size_s1);
			end
			K_AND, K_OR, K_XOR, K_TEST: begin
				res  = (kind_s1 == K_TEST) ? a : logic_v;
				nf.c = 1'b0;
				nf.o = 1'b0;
				nf.z = (logic_v == '0);
				nf.s = msb_of(logic_v, size_s1);
			end
			K_SHR: begin
				if (cnt != '0) begin
					res  = shr_v;
					nf.c = shr_c;
					if (cnt == 5'd1) begin
						nf.o = sa;
					end
					nf.z = (shr_v == '0);
					nf.s = msb_of(shr_v, size_s1);
				end
			end
			K_SAR: begin
				if (cnt != '0) begin
					res  = sar_v;
					nf.c = sar_c;
					if (cnt == 5'd1) begin
						nf.o = 1'b0;
					end
					nf.z = (sar_v == '0);
					nf.s = msb_of(sar_v, size_s1);
				end
			end
			K_SHL: begin
				if (cnt != '0) begin
					res  = shl_v;
					nf.c = shl_c;
					if (cnt == 5'd1) begin
						nf.o = shl_c ^ msb_of(shl_v, size_s1);
					end
					nf.z = (shl_v == '0);
					nf.s = msb_of(shl_v, size_s1);
				end
			end
			K_ROL: res = rotate(a, size_s1, cnt, 1'b1);
			K_ROR: res = rotate(a, size_s1, cnt, 1'b0);
			K_NEG: res = (32'd0 - a) & mask;
			default: res = a;
		endcase
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.result_value = result_q;
	assign rsp.carry_out    = flags_q.c;
	assign rsp.zero_out     = flags_q.z;
	assign rsp.sign_out     = flags_q.s;
	assign rsp.overflow_out = flags_q.o;

	// sb only feeds the add overflow check below
	a_inc_dec_keep_carry: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (kind_s1 == K_INC || kind_s1 == K_DEC)
		|=> rsp.carry_out == $past(flags_q.c))
		else $error("inc/dec changed carry");

	a_logic_clears_co: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (kind_s1 == K_AND || kind_s1 == K_OR || kind_s1 == K_XOR ||
			kind_s1 == K_TEST)
		|=> !rsp.carry_out && !rsp.overflow_out)
		else $error("logic op left carry or overflow set");

	a_rot_neg_keep_flags: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (kind_s1 == K_ROL || kind_s1 == K_ROR || kind_s1 == K_NEG)
		|=> $stable(flags_q))
		else $error("rotate/neg changed flags");

	a_cmp_test_keep_dest: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (kind_s1 == K_CMP || kind_s1 == K_TEST)
		|=> rsp.result_value == $past(a))
		else $error("cmp/test changed destination");

	a_add_overflow_sign: assert property (@(posedge clk) disable iff (!arst_n)
		advance && kind_s1 == K_ADD && (sa != sb)
		|=> !rsp.overflow_out)
		else $error("add of mixed signs overflowed");

endmodule
